// File: rtl/gbp_pkg.sv
package gbp_pkg;

  // Table sizes. Both must be powers of two, since the indexes are plain
  // bit fields of the address.
  localparam int BTB_ENTRIES = 1024;
  localparam int PHT_ENTRIES = 256;

  localparam int BTB_IDX_W = $clog2(BTB_ENTRIES);
  localparam int PHT_IDX_W = $clog2(PHT_ENTRIES);

  localparam int PC_W     = 64;
  localparam int HIST_W   = 8;
  localparam int CTR_W    = 2;

  // Byte offset of an instruction within the fetch address.
  localparam int PC_LSB   = 2;
  localparam logic [PC_W-1:0] PC_STEP = PC_W'(4);

  // Two-bit saturating counter limits and the predict-taken threshold.
  localparam logic [CTR_W-1:0] CTR_MAX   = CTR_W'(3);
  localparam logic [CTR_W-1:0] CTR_MIN   = CTR_W'(0);
  localparam logic [CTR_W-1:0] CTR_TAKEN = CTR_W'(2);

  // The clearing pass after reset covers the larger of the two tables.
  localparam int CLEAR_CNT = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
  localparam int CLR_W     = $clog2(CLEAR_CNT);

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic            ok;
    logic            cond;
    logic [PC_W-1:0] tag;
    logic [PC_W-1:0] target;
  } btb_line_t;

endpackage

// File: rtl/gbp_req_if.sv
interface gbp_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] pc;
  logic [63:0] target;
  logic        is_conditional;
  logic        entry_valid;
  logic        taken;

  modport source (
    output valid, cmd, pc, target, is_conditional, entry_valid, taken,
    input  ready
  );

  modport sink (
    input  valid, cmd, pc, target, is_conditional, entry_valid, taken,
    output ready
  );
endinterface

// File: rtl/gbp_rsp_if.sv
interface gbp_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;

  modport source (
    output valid, next_pc,
    input  ready
  );

  modport sink (
    input  valid, next_pc,
    output ready
  );
endinterface

// File: rtl/gshare_btb_branch_predictor_core.sv
// Gshare branch predictor with a 1024-entry direct-mapped branch target
// buffer and a 256-entry table of two-bit counters indexed by fetch address
// bits 2..9 XOR an 8-bit global history. A predict item (cmd 0) returns one
// item on rsp holding the predicted next fetch address; an update item
// (cmd 1) returns nothing and rewrites the buffer entry, trains the counter
// and shifts the history when the branch is conditional. Both tables live in
// synchronous memories with a registered read, so every item is accepted in
// ST_IDLE, where the tables are read, and finished in ST_LOOKUP, which forms
// the prediction or writes back the trained counter. No new item is accepted
// until the last one has left ST_LOOKUP; a pending prediction waits in the
// output register, so the next item can be accepted while rsp is stalled.
// After reset the block runs a clearing pass over the tables, during which
// req.ready stays low.
module gshare_btb_branch_predictor_core
  import gbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  gbp_req_if.sink   req,
  gbp_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;

  // Clearing pass position.
  logic [CLR_W-1:0] clr_idx;

  // Global outcome history, newest outcome in bit 0.
  logic [HIST_W-1:0] history;

  // Fields of the item in flight, held while the tables are read.
  cmd_t                 pend_cmd;
  logic [PC_W-1:0]      pend_pc;
  logic [PHT_IDX_W-1:0] pend_pidx;
  logic                 pend_cond;
  logic                 pend_taken;

  // Output register.
  logic            out_valid;
  logic [PC_W-1:0] out_pc;

  // Memories and their registered read data.
  btb_line_t       btb_mem [BTB_ENTRIES];
  logic [CTR_W-1:0] pht_mem [PHT_ENTRIES];
  btb_line_t       btb_rd;
  logic [CTR_W-1:0] pht_rd;

  logic                           accept;
  logic [BTB_IDX_W-1:0]           req_bidx;
  logic [PHT_IDX_W+HIST_W-1:0]    hist_ext;
  logic [PHT_IDX_W-1:0]           req_pidx;
  logic                           clr_btb;
  logic                           clr_pht;
  logic                           clr_last;
  logic                           pht_train;
  logic [CTR_W-1:0]               ctr_next;
  logic                           hit;
  logic [PC_W-1:0]                pred_pc;
  logic                           out_free;
  logic                           out_load;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // Buffer index is pc bits 2 and up; the counter index folds in the history.
  assign req_bidx = req.pc[PC_LSB +: BTB_IDX_W];
  assign hist_ext = {{PHT_IDX_W{1'b0}}, history};
  assign req_pidx = req.pc[PC_LSB +: PHT_IDX_W] ^ hist_ext[PHT_IDX_W-1:0];

  // The clearing pass runs over the larger table and only touches the
  // smaller one while its index is in range.
  assign clr_btb  = (state == ST_CLEAR) &&
                    ({1'b0, clr_idx} < (CLR_W+1)'(BTB_ENTRIES));
  assign clr_pht  = (state == ST_CLEAR) &&
                    ({1'b0, clr_idx} < (CLR_W+1)'(PHT_ENTRIES));
  assign clr_last = (clr_idx == CLR_W'(CLEAR_CNT - 1));

  // Saturating counter step for a conditional update.
  assign pht_train = (state == ST_LOOKUP) && (pend_cmd == CMD_UPDATE) && pend_cond;

  always_comb begin
    ctr_next = pht_rd;
    if (pend_taken) begin
      if (pht_rd != CTR_MAX) begin
        ctr_next = pht_rd + CTR_W'(1);
      end
    end else begin
      if (pht_rd != CTR_MIN) begin
        ctr_next = pht_rd - CTR_W'(1);
      end
    end
  end

  // Prediction: a valid entry whose full tag matches redirects fetch when it
  // is unconditional or its counter leans taken.
  assign hit     = btb_rd.ok && (btb_rd.tag == pend_pc) &&
                   (!btb_rd.cond || (pht_rd >= CTR_TAKEN));
  assign pred_pc = hit ? btb_rd.target : (pend_pc + PC_STEP);

  assign out_free = !out_valid || rsp.ready;

  // A finished prediction moves into the output register once it is free.
  assign out_load = (state == ST_LOOKUP) && (pend_cmd == CMD_PREDICT) && out_free;

  // Branch target buffer. The entry is written as soon as an update is
  // accepted; a predict reads it in the same accept cycle.
  always_ff @(posedge clk) begin
    if (clr_btb) begin
      btb_mem[clr_idx[BTB_IDX_W-1:0]] <= '0;
    end else if (accept && (req.cmd == CMD_UPDATE)) begin
      btb_mem[req_bidx] <= '{ok: req.entry_valid, cond: req.is_conditional,
                             tag: req.pc, target: req.target};
    end
    if (accept) begin
      btb_rd <= btb_mem[req_bidx];
    end
  end

  // Counter table, read on accept and written back in the following cycle. No item
  // is accepted during the write-back, so a read never overlaps it.
  always_ff @(posedge clk) begin
    if (clr_pht) begin
      pht_mem[clr_idx[PHT_IDX_W-1:0]] <= '0;
    end else if (pht_train) begin
      pht_mem[pend_pidx] <= ctr_next;
    end
    if (accept) begin
      pht_rd <= pht_mem[req_pidx];
    end
  end

  // Control, history and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      history   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_pc    <= pred_pc;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + CLR_W'(1);
          if (clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (pend_cmd == CMD_PREDICT) begin
            // Hold the read data until the output register can take it.
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            if (pend_cond) begin
              history <= {history[HIST_W-2:0], pend_taken};
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item fields captured at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd   <= cmd_t'(req.cmd);
      pend_pc    <= req.pc;
      pend_pidx  <= req_pidx;
      pend_cond  <= req.is_conditional;
      pend_taken <= req.taken;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.next_pc = out_pc;

endmodule
